// ===== hdl/mavg_pkg.sv =====
// ----------------------------------------------------------------------------
// Moving-average filter package
// Widths, register indexes, reset values and the sequencer state type.
// ----------------------------------------------------------------------------
package mavg_pkg;

	localparam int SAMPLE_W         = 16;
	localparam int TAP_W            = 6;
	localparam int SUM_W            = SAMPLE_W + TAP_W;
	localparam int MAG_W            = SUM_W - 1;
	localparam int MEAN_W           = SAMPLE_W + 1;
	localparam int MAX_TAPS_DEFAULT = 64;
	localparam int CFG_AW           = 4;
	localparam int CFG_DW           = 32;

	localparam logic [TAP_W-1:0] TAP_RESET = TAP_W'(30);

	localparam logic [1:0] REG_TAP_COUNT = 2'd0;
	localparam logic [1:0] REG_HIGH_PASS = 2'd1;
	localparam logic [1:0] REG_MONO      = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRITE,
		ST_SUM,
		ST_DRAIN,
		ST_DL_GO,
		ST_DL_WAIT,
		ST_DR_GO,
		ST_DR_WAIT,
		ST_FIN
	} st_t;

endpackage

// ===== hdl/mavg_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mavg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/mavg_div.sv =====
// ----------------------------------------------------------------------------
// Iterative signed divider
// Restoring division of the ring sum by the tap count, one quotient bit per
// cycle, truncated toward zero.
// ----------------------------------------------------------------------------
module mavg_div
	import mavg_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [SUM_W-1:0]  dividend,
	input  logic [TAP_W-1:0]         divisor,
	output logic                     done,
	output logic signed [MEAN_W-1:0] quotient
);

	localparam int CNT_W = $clog2(MAG_W + 1);

	logic [MAG_W-1:0]  qr_q;
	logic [TAP_W:0]    rem_q;
	logic [TAP_W-1:0]  dvs_q;
	logic              neg_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;

	logic [SUM_W-1:0]  mag_full;
	logic [TAP_W:0]    rem_sh;
	logic [TAP_W+1:0]  diff;
	logic              ge;
	logic [MEAN_W-1:0] q_mag;

	assign mag_full = dividend[SUM_W-1] ? (-dividend) : dividend;
	assign rem_sh   = {rem_q[TAP_W-1:0], qr_q[MAG_W-1]};
	assign diff     = {1'b0, rem_sh} - {2'b00, dvs_q};
	assign ge       = ~diff[TAP_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(MAG_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			qr_q  <= mag_full[MAG_W-1:0];
			rem_q <= '0;
			dvs_q <= divisor;
			neg_q <= dividend[SUM_W-1];
		end else if (cnt_q != '0) begin
			qr_q  <= {qr_q[MAG_W-2:0], ge};
			rem_q <= ge ? diff[TAP_W:0] : rem_sh;
		end
	end

	assign q_mag    = qr_q[MEAN_W-1:0];
	assign quotient = neg_q ? signed'(-q_mag) : signed'(q_mag);
	assign done     = done_q;

endmodule

// ===== hdl/moving_average_low_high_pass.sv =====
// ----------------------------------------------------------------------------
// Boxcar moving-average filter, low or high pass
// Per-channel rings of the last taps samples; output is the ring mean or
// the sample minus the mean. Mono or stereo, pass-through at taps zero.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------
//   in       | in_valid / in_stall    | sample_left, sample_right
//   out      | out_valid / out_stall  | filtered_left, filtered_right
//   config   | APB psel/penable/...   | tap_count, high_pass_mode, mono
//
// A beat runs the ring sweep (one RAM read per tap) and then the shared 21-step
// divider, once for the left channel and again for the right one in stereo.
// in_stall is high from accept until the result is loaded into the output
// register; a result waiting under out_stall does not block the next accept.
// Reset clears rings (per-entry valid bits), slot, state, config and out_valid at once.
// ----------------------------------------------------------------------------
module moving_average_low_high_pass
	import mavg_pkg::*;
#(
	parameter int MAX_TAPS = MAX_TAPS_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample_left,
	input  logic signed [SAMPLE_W-1:0] sample_right,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] filtered_left,
	output logic signed [SAMPLE_W-1:0] filtered_right,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [CFG_AW-1:0]          paddr,
	input  logic [CFG_DW-1:0]          pwdata,
	output logic [CFG_DW-1:0]          prdata,
	output logic                       pready
);

	localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int CW = ((AW > TAP_W) ? AW : TAP_W) + 1;

	st_t state_q, state_d;

	logic [TAP_W-1:0] tap_count_q;
	logic             hp_q;
	logic             mono_q;

	logic signed [SAMPLE_W-1:0] smp_l_q, smp_r_q;
	logic [TAP_W-1:0]           taps_q;
	logic [AW-1:0]              slot_q, wr_slot_q, k_q;
	logic [MAX_TAPS-1:0]        vld_l_q, vld_r_q;
	logic                       rd_s1, vld_l_s1, vld_r_s1;
	logic signed [SUM_W-1:0]    sum_l_q, sum_r_q;
	logic [SAMPLE_W-1:0]        res_l_q, res_r_q;
	logic                       out_valid_q;
	logic [SAMPLE_W-1:0]        filt_l_q, filt_r_q;

	logic [TAP_W-1:0]           taps_eff;
	logic [AW-1:0]              slot_eff;
	logic                       last_k;
	logic [SAMPLE_W-1:0]        rd_l, rd_r;
	logic                       cfg_we;

	logic                       accept, ram_we, rd_issue, div_start, fin_load;
	logic signed [SUM_W-1:0]    div_dividend;
	logic                       div_done;
	logic signed [MEAN_W-1:0]   div_quot;
	logic signed [MEAN_W-1:0]   smp_sel, hp_diff;
	logic [SAMPLE_W-1:0]        res_new;

	// configuration
	assign cfg_we = psel & penable & pwrite & pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_RESET;
			hp_q        <= 1'b0;
			mono_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (paddr[3:2])
				REG_TAP_COUNT: tap_count_q <= pwdata[TAP_W-1:0];
				REG_HIGH_PASS: hp_q        <= pwdata[0];
				REG_MONO:      mono_q      <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_TAP_COUNT: prdata = CFG_DW'(tap_count_q);
			REG_HIGH_PASS: prdata = CFG_DW'(hp_q);
			REG_MONO:      prdata = CFG_DW'(mono_q);
			default:       prdata = '0;
		endcase
	end

	// tap count clamp and slot check
	assign taps_eff = (CW'(tap_count_q) > CW'(MAX_TAPS)) ? TAP_W'(MAX_TAPS) : tap_count_q;
	assign slot_eff = (CW'(slot_q) < CW'(taps_eff)) ? slot_q : '0;
	assign last_k   = (CW'(k_q) == (CW'(taps_q) - CW'(1)));

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (in_valid) state_d = (taps_eff == '0) ? ST_FIN : ST_WRITE;
			ST_WRITE:   state_d = ST_SUM;
			ST_SUM:     if (last_k) state_d = ST_DRAIN;
			ST_DRAIN:   state_d = ST_DL_GO;
			ST_DL_GO:   state_d = ST_DL_WAIT;
			ST_DL_WAIT: if (div_done) state_d = mono_q ? ST_FIN : ST_DR_GO;
			ST_DR_GO:   state_d = ST_DR_WAIT;
			ST_DR_WAIT: if (div_done) state_d = ST_FIN;
			ST_FIN:     if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall     = (state_q != ST_IDLE);
		accept       = (state_q == ST_IDLE) && in_valid;
		ram_we       = (state_q == ST_WRITE);
		rd_issue     = (state_q == ST_SUM);
		div_start    = (state_q == ST_DL_GO) || (state_q == ST_DR_GO);
		div_dividend = (state_q == ST_DR_GO) ? sum_r_q : sum_l_q;
		fin_load     = (state_q == ST_FIN) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_q      <= '0;
			vld_l_q     <= '0;
			vld_r_q     <= '0;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_s1   <= rd_issue;
			if (ram_we) begin
				vld_l_q[wr_slot_q] <= 1'b1;
				if (!mono_q) begin
					vld_r_q[wr_slot_q] <= 1'b1;
				end
				slot_q <= ((CW'(wr_slot_q) + CW'(1)) == CW'(taps_q)) ? '0
				          : (wr_slot_q + 1'b1);
			end
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// rings
	mavg_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_ring_l (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_slot_q),
		.wdata (smp_l_q),
		.raddr (k_q),
		.rdata (rd_l)
	);

	mavg_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_ring_r (
		.clk   (clk),
		.we    (ram_we & ~mono_q),
		.waddr (wr_slot_q),
		.wdata (smp_r_q),
		.raddr (k_q),
		.rdata (rd_r)
	);

	// shared divider
	mavg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (taps_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign smp_sel = (state_q == ST_DR_WAIT) ? MEAN_W'(smp_r_q) : MEAN_W'(smp_l_q);
	assign hp_diff = smp_sel - div_quot;
	assign res_new = hp_q ? hp_diff[SAMPLE_W-1:0] : div_quot[SAMPLE_W-1:0];

	// datapath
	always_ff @(posedge clk) begin
		vld_l_s1 <= vld_l_q[k_q];
		vld_r_s1 <= vld_r_q[k_q];
		if (accept) begin
			smp_l_q   <= sample_left;
			smp_r_q   <= sample_right;
			taps_q    <= taps_eff;
			wr_slot_q <= slot_eff;
			res_l_q   <= sample_left;
			res_r_q   <= mono_q ? '0 : sample_right;
		end
		if (ram_we) begin
			k_q     <= '0;
			sum_l_q <= '0;
			sum_r_q <= '0;
		end else if (rd_issue) begin
			k_q <= k_q + 1'b1;
		end
		if (rd_s1) begin
			sum_l_q <= sum_l_q + (vld_l_s1
			           ? {{(SUM_W-SAMPLE_W){rd_l[SAMPLE_W-1]}}, rd_l} : SUM_W'(0));
			sum_r_q <= sum_r_q + (vld_r_s1
			           ? {{(SUM_W-SAMPLE_W){rd_r[SAMPLE_W-1]}}, rd_r} : SUM_W'(0));
		end
		if (div_done && state_q == ST_DL_WAIT) begin
			res_l_q <= res_new;
			if (mono_q) begin
				res_r_q <= '0;
			end
		end
		if (div_done && state_q == ST_DR_WAIT) begin
			res_r_q <= res_new;
		end
		if (fin_load) begin
			filt_l_q <= res_l_q;
			filt_r_q <= res_r_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign filtered_left  = filt_l_q;
	assign filtered_right = filt_r_q;

	// checks
	a_pass_short: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && tap_count_q == '0) |=> (state_q == ST_FIN))
		else $error("pass-through beat did not go straight to output");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DL_WAIT || state_q == ST_DR_WAIT))
		else $error("divider finished outside a wait state");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(slot_q) < CW'(MAX_TAPS))
		else $error("write slot beyond ring depth");

endmodule
